// ===== hdl/ptrt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic task release table: shared types and constants
// Slot geometry, period/offset ROMs, payload words and control structs.
// ----------------------------------------------------------------------------
package ptrt_pkg;

   localparam int NUM_CORES          = 3;
   localparam int NUM_PERIOD_CLASSES = 10;
   localparam int MAX_CLASSES        = 16;
   localparam int FLAG_BITS          = 30;
   localparam int NUM_SLOTS          = NUM_CORES * NUM_PERIOD_CLASSES;
   // slots past the flag word never fire, so the walk stops there
   localparam int SWEEP_SLOTS = (NUM_SLOTS < FLAG_BITS) ? NUM_SLOTS : FLAG_BITS;
   localparam int SLOT_W      = (SWEEP_SLOTS > 1) ? $clog2(SWEEP_SLOTS) : 1;
   localparam int CNT_W       = 14;

   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [SLOT_W-1:0]    slot_type;
   typedef logic [FLAG_BITS-1:0] flags_type;

   localparam cnt_type PERIOD_ROM [MAX_CLASSES] = '{
      14'd10, 14'd20, 14'd50, 14'd100, 14'd200, 14'd500, 14'd1000, 14'd2000,
      14'd5000, 14'd10000, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0
   };

   typedef enum logic {
      ACT_TICK  = 1'b0,
      ACT_CLEAR = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      CSR_ENABLE_MASK = 2'd0,
      CSR_RUN_LENGTH  = 2'd1,
      CSR_CLOCK_STEP  = 2'd2
   } csr_idx_type;

   typedef struct packed {
      action_type  action;
      logic [1:0]  core_index;
      logic [3:0]  period_class;
   } req_type;

   typedef struct packed {
      logic [29:0] pending_flags;
      logic [31:0] clock_us;
      logic        terminated;
   } rsp_type;

   typedef struct packed {
      logic     rd_en;
      slot_type rd_addr;
      logic     wr_en;
      slot_type wr_addr;
      cnt_type  wr_data;
   } mem_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sweep_stat_type;

   function automatic cnt_type slot_period(slot_type s);
      cnt_type r;
      r = '0;
      for (int c = 0; c < NUM_CORES; c++) begin
         for (int p = 0; p < NUM_PERIOD_CLASSES && p < MAX_CLASSES; p++) begin
            if (int'(s) == c * NUM_PERIOD_CLASSES + p) begin
               r = PERIOD_ROM[p];
            end
         end
      end
      return r;
   endfunction

   // release offset in ticks; doubles as the counter value after reset
   function automatic cnt_type slot_offset(slot_type s);
      cnt_type r;
      r = '0;
      for (int c = 0; c < NUM_CORES; c++) begin
         for (int p = 0; p < NUM_PERIOD_CLASSES && p < MAX_CLASSES; p++) begin
            if (int'(s) == c * NUM_PERIOD_CLASSES + p) begin
               if (c == 0 && p == 3) begin
                  r = 14'd20;
               end else if (c == 1 && p == 9) begin
                  r = 14'd750;
               end
            end
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/ptrt_cnt_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Slot countdown memory
// One entry per slot: ticks left to the next release. Unwritten entries read
// as the slot offset (per-entry valid bits, cleared by reset).
// ----------------------------------------------------------------------------
module ptrt_cnt_mem (
   input  wire                     clock,
   input  wire                     reset,
   input  ptrt_pkg::mem_req_type   mem_req,
   output ptrt_pkg::cnt_type       rd_data
);
   import ptrt_pkg::*;

   cnt_type                  mem [SWEEP_SLOTS];
   logic [SWEEP_SLOTS-1:0]   valid_ff;
   cnt_type                  rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_req.wr_en) begin
         valid_ff[mem_req.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= valid_ff[mem_req.rd_addr] ? mem[mem_req.rd_addr]
                                                 : slot_offset(mem_req.rd_addr);
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/ptrt_sweep.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Slot sweep engine
// Walks all slots once per tick: read counter, decrement or reload, write
// back, and collect the release bits of enabled slots.
// ----------------------------------------------------------------------------
module ptrt_sweep (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   input  ptrt_pkg::flags_type        en_mask,
   output ptrt_pkg::sweep_stat_type   stat,
   output ptrt_pkg::flags_type        fire,
   output ptrt_pkg::mem_req_type      mem_req,
   input  ptrt_pkg::cnt_type          rd_data
);
   import ptrt_pkg::*;

   localparam slot_type LAST_SLOT = slot_type'(SWEEP_SLOTS - 1);

   typedef enum logic {
      S_IDLE,
      S_RUN
   } state_type;

   state_type  state_ff;
   slot_type   rd_slot_ff;
   logic       p_vld_ff;
   slot_type   p_slot_ff;
   logic       done_ff;
   flags_type  fire_ff;

   cnt_type    cur_per;
   logic       hit;
   cnt_type    new_cnt;

   always_comb begin
      cur_per = slot_period(p_slot_ff);
      hit     = (rd_data == '0) && (cur_per != '0);
      if (hit) begin
         new_cnt = cur_per - cnt_type'(1);
      end else if (rd_data == '0) begin
         new_cnt = rd_data;
      end else begin
         new_cnt = rd_data - cnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rd_slot_ff <= '0;
         p_vld_ff   <= 1'b0;
         p_slot_ff  <= '0;
         done_ff    <= 1'b0;
         fire_ff    <= '0;
      end else begin
         done_ff <= p_vld_ff && (p_slot_ff == LAST_SLOT);
         if (p_vld_ff && hit && en_mask[p_slot_ff]) begin
            fire_ff[p_slot_ff] <= 1'b1;
         end
         unique case (state_ff)
            S_IDLE: begin
               p_vld_ff <= 1'b0;
               if (start) begin
                  state_ff   <= S_RUN;
                  rd_slot_ff <= '0;
                  fire_ff    <= '0;
               end
            end
            S_RUN: begin
               p_vld_ff  <= 1'b1;
               p_slot_ff <= rd_slot_ff;
               if (rd_slot_ff == LAST_SLOT) begin
                  state_ff <= S_IDLE;
               end else begin
                  rd_slot_ff <= rd_slot_ff + slot_type'(1);
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      mem_req.rd_en   = (state_ff == S_RUN);
      mem_req.rd_addr = rd_slot_ff;
      mem_req.wr_en   = p_vld_ff;
      mem_req.wr_addr = p_slot_ff;
      mem_req.wr_data = new_cnt;
   end

   assign stat.busy = (state_ff == S_RUN) || p_vld_ff || done_ff;
   assign stat.done = done_ff;
   assign fire      = fire_ff;

endmodule
`default_nettype wire

// ===== hdl/periodic_task_release_table.sv =====
`default_nettype none
// A clear word or an ignored tick is answered from the output word register.
// An active tick launches the walk, the counter memory is walked one slot per
//   cycle (30 slots); the last slot passes the read and done registers into
//   the output word register. No word is taken while a walk runs.
// Throughput: clears one per cycle while the output word is not stalled.
// Reset (sync, active high): flags, clock, tick count and terminated clear;
//   counter entries are marked unwritten and read as the slot offset.
// ----------------------------------------------------------------------------
// Periodic task release table
// Time-triggered activation for 3 cores x 10 period classes. Per-slot
// countdowns in a memory replace the (t - offset) mod period test.
// ----------------------------------------------------------------------------
module periodic_task_release_table (
   input  wire                clock,
   input  wire                reset,
   // request channel
   input  wire                req_valid,
   output logic               req_ready,
   input  ptrt_pkg::req_type  req_data,
   // response channel
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output ptrt_pkg::rsp_type  rsp_data,
   // register write port
   input  wire                csr_we,
   input  wire [1:0]          csr_index,
   input  wire [29:0]         csr_wdata
);
   import ptrt_pkg::*;

   // configuration
   flags_type       mask_ff;
   logic [23:0]     run_ff;
   logic [15:0]     step_ff;

   // architectural state
   flags_type       pending_ff,   pending_in;
   logic [23:0]     tick_ff,      tick_in;
   logic [31:0]     clk_us_ff,    clk_us_in;
   logic            done_ff,      done_in;
   logic            busy_ff,      busy_in;

   // output word register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff,  rsp_data_in;

   logic            req_acc;
   logic            start;
   logic [23:0]     tick_next;
   sweep_stat_type  sweep_stat;
   flags_type       fire;
   mem_req_type     mem_req;
   cnt_type         mem_rd_data;

   ptrt_cnt_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   ptrt_sweep u_sweep (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .en_mask (mask_ff),
      .stat    (sweep_stat),
      .fire    (fire),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   // take a word only when no sweep runs and the output slot frees up
   assign req_ready = !busy_ff && (!rsp_valid_ff || rsp_ready);
   assign req_acc   = req_valid && req_ready;
   // tick that really advances time: not terminated, still below run length
   assign start     = req_acc && (req_data.action == ACT_TICK) && !done_ff &&
                      (tick_ff < run_ff);
   assign tick_next = tick_ff + 24'd1;

   always_comb begin
      pending_in   = pending_ff;
      tick_in      = tick_ff;
      clk_us_in    = clk_us_ff;
      done_in      = done_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (start) begin
         // clock moves now, flags and tick count at the end of the walk
         clk_us_in = clk_us_ff + 32'(step_ff);
         busy_in   = 1'b1;
      end else if (req_acc) begin
         if (req_data.action == ACT_TICK) begin
            // ignored tick; a reached run length terminates
            done_in = 1'b1;
         end else begin
            for (int c = 0; c < NUM_CORES; c++) begin
               for (int p = 0; p < NUM_PERIOD_CLASSES; p++) begin
                  if (int'(req_data.core_index) == c &&
                      int'(req_data.period_class) == p &&
                      c * NUM_PERIOD_CLASSES + p < FLAG_BITS) begin
                     pending_in[c * NUM_PERIOD_CLASSES + p] = 1'b0;
                  end
               end
            end
         end
         rsp_valid_in              = 1'b1;
         rsp_data_in.pending_flags = pending_in;
         rsp_data_in.clock_us      = clk_us_ff;
         rsp_data_in.terminated    = done_in;
      end

      if (sweep_stat.done) begin
         // set-only merge: a release on a set flag is lost
         pending_in                = pending_ff | fire;
         tick_in                   = tick_next;
         done_in                   = (tick_next >= run_ff);
         busy_in                   = 1'b0;
         rsp_valid_in              = 1'b1;
         rsp_data_in.pending_flags = pending_in;
         rsp_data_in.clock_us      = clk_us_ff;
         rsp_data_in.terminated    = done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= flags_type'(655432);
         run_ff       <= 24'd100000;
         step_ff      <= 16'd100;
         pending_ff   <= '0;
         tick_ff      <= '0;
         clk_us_ff    <= '0;
         done_ff      <= 1'b0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ENABLE_MASK: mask_ff <= csr_wdata;
               CSR_RUN_LENGTH:  run_ff  <= csr_wdata[23:0];
               CSR_CLOCK_STEP:  step_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
         pending_ff   <= pending_in;
         tick_ff      <= tick_in;
         clk_us_ff    <= clk_us_in;
         done_ff      <= done_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------

   // no word may enter while the slot walk is under way
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sweep_stat.busy |-> !req_ready)
      else $error("request accepted during slot sweep");

   // end of a walk always presents a word
   a_sweep_gives_word: assert property (@(posedge clock) disable iff (reset)
      sweep_stat.done |=> rsp_valid_ff)
      else $error("sweep finished without response word");

   // the microsecond clock moves only on an active tick
   a_clock_on_tick: assert property (@(posedge clock) disable iff (reset)
      !start |=> $stable(clk_us_ff))
      else $error("clock changed without an active tick");

   // flags rise only when a walk completes
   a_flags_rise_at_sweep: assert property (@(posedge clock) disable iff (reset)
      ((pending_ff & ~$past(pending_ff)) != '0) |-> $past(sweep_stat.done))
      else $error("pending flag set outside sweep end");

   // termination is sticky
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> done_ff)
      else $error("terminated flag dropped");

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Periodic task release table testbench
// Streams tick and clear words through the block with random bursts, gaps
// and response stalls. A shadow of the release table predicts the flag word,
// the microsecond clock and the terminated bit for every accepted word.
// ----------------------------------------------------------------------------
module testbench;
   import ptrt_pkg::*;

   localparam int LIMIT = 600000;   // cycles before the run is declared hung

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   wire         req_ready;
   req_type     req_data = '0;
   wire         rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [29:0] csr_wdata = '0;

   periodic_task_release_table u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // Shadow of the release table
   // ------------------------------------------------------------------------
   // ticks per period class
   int unsigned class_period [10] = '{10, 20, 50, 100, 200, 500, 1000, 2000,
                                      5000, 10000};

   // register copies, reset values
   logic [29:0] enable_mask_sh = 30'd655432;
   logic [23:0] run_length_sh  = 24'd100000;
   logic [15:0] clock_step_sh  = 16'd100;

   // table state
   logic [29:0] flags_sh      = '0;
   logic [23:0] tick_count_sh = '0;
   logic [31:0] clock_us_sh   = '0;
   logic        terminated_sh = 1'b0;

   // Applies one word to the shadow and returns the status it must produce.
   function automatic rsp_type advance_release_table(req_type w);
      rsp_type     r;
      int unsigned t;
      int unsigned slot;
      int unsigned offset;
      t = 32'(tick_count_sh);
      if (w.action == ACT_TICK) begin
         if (terminated_sh) begin
            // ticks after the end change nothing
         end else if (t >= 32'(run_length_sh)) begin
            // run length lowered to or below the count: tick dropped, run ends
            terminated_sh = 1'b1;
         end else begin
            clock_us_sh = clock_us_sh + 32'(clock_step_sh);
            for (int c = 0; c < NUM_CORES; c++) begin
               for (int p = 0; p < NUM_PERIOD_CLASSES; p++) begin
                  slot = c * NUM_PERIOD_CLASSES + p;
                  // only two slots release late
                  offset = (c == 0 && p == 3) ? 20 : (c == 1 && p == 9) ? 750 : 0;
                  if (enable_mask_sh[slot] && t >= offset &&
                      (t - offset) % class_period[p] == 0) begin
                     flags_sh[slot] = 1'b1;   // an already set flag swallows it
                  end
               end
            end
            tick_count_sh = tick_count_sh + 24'd1;
            if (tick_count_sh >= run_length_sh) begin
               terminated_sh = 1'b1;
            end
         end
      end else if (w.core_index < NUM_CORES && w.period_class < NUM_PERIOD_CLASSES) begin
         // clears keep working after termination
         flags_sh[w.core_index * NUM_PERIOD_CLASSES + w.period_class] = 1'b0;
      end
      r.pending_flags = flags_sh;
      r.clock_us      = clock_us_sh;
      r.terminated    = terminated_sh;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Request side: bursts of words with random gaps in between
   // ------------------------------------------------------------------------
   req_type req_word_q [$];      // words waiting to go out
   rsp_type release_status_q [$];   // status each accepted word must produce

   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 1;
         gap_left   = 0;
      end else if (!(req_valid && !req_ready)) begin
         // nothing held: either idle through a gap or present the next word
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (req_word_q.size() > 0) begin
            req_data  <= req_word_q.pop_front();
            req_valid <= 1'b1;
            burst_left = burst_left - 1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               // a third of the bursts run straight into the next one
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response side: predict on accept, check on response, stall by mode
   // ------------------------------------------------------------------------
   int mismatch_count = 0;
   int stall_mode     = 0;
   int mode_cycles    = 0;

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         // predict first so a same-edge response never looks unexpected
         if (req_valid && req_ready) begin
            release_status_q.push_back(advance_release_table(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (release_status_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("ERROR: unexpected status word flags=%h clock=%h term=%b",
                           rsp_data.pending_flags, rsp_data.clock_us,
                           rsp_data.terminated);
               end
            end else begin
               want = release_status_q.pop_front();
               if (rsp_data.pending_flags !== want.pending_flags ||
                   rsp_data.clock_us !== want.clock_us ||
                   rsp_data.terminated !== want.terminated) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("ERROR: flags exp %h got %h, clock exp %h got %h, term exp %b got %b",
                              want.pending_flags, rsp_data.pending_flags,
                              want.clock_us, rsp_data.clock_us,
                              want.terminated, rsp_data.terminated);
                  end
               end
            end
         end
         // stall pattern: always ready, coin flip, or mostly stalled; new mode
         // whenever mode_cycles runs out
         if (mode_cycles == 0) begin
            stall_mode  = $urandom_range(0, 2);
            mode_cycles = 50;
         end
         mode_cycles = mode_cycles - 1;
         case (stall_mode)
            0: begin
               rsp_ready <= 1'b1;
            end
            1: begin
               rsp_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
               rsp_ready <= ($urandom_range(0, 4) == 0);
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Run limit
   // ------------------------------------------------------------------------
   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic push_word(action_type a, logic [1:0] core, logic [3:0] cls);
      req_type w;
      w.action       = a;
      w.core_index   = core;
      w.period_class = cls;
      req_word_q.push_back(w);
   endtask

   // Mostly ticks; clears usually hit a real slot, sometimes an absent one.
   task automatic push_random(int count, int tick_pct);
      req_type w;
      repeat (count) begin
         w.core_index   = 2'($urandom_range(0, 3));
         w.period_class = 4'($urandom_range(0, 15));
         if ($urandom_range(0, 99) < tick_pct) begin
            w.action = ACT_TICK;
         end else begin
            w.action = ACT_CLEAR;
            if ($urandom_range(0, 9) != 0) begin
               w.core_index   = 2'($urandom_range(0, NUM_CORES - 1));
               w.period_class = 4'($urandom_range(0, NUM_PERIOD_CLASSES - 1));
            end
         end
         req_word_q.push_back(w);
      end
   endtask

   // Block until every queued word is accepted and answered.
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (req_word_q.size() != 0 || req_valid || release_status_q.size() != 0);
   endtask

   task automatic csr_write(csr_idx_type idx, logic [29:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_ENABLE_MASK: enable_mask_sh = value;
         CSR_RUN_LENGTH:  run_length_sh  = value[23:0];
         default:         clock_step_sh  = value[15:0];
      endcase
   endtask

   // Reprogram all three registers once the table is quiet.
   task automatic program_table(logic [29:0] mask, logic [23:0] run_len, logic [15:0] step);
      wait_drained();
      csr_write(CSR_ENABLE_MASK, mask);
      csr_write(CSR_RUN_LENGTH, {6'd0, run_len});
      csr_write(CSR_CLOCK_STEP, {14'd0, step});
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   logic [23:0] final_run_length;

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: t=0 fires the zero-offset slots 6 and 17
      push_word(ACT_TICK,  2'd3, 4'd15);
      push_word(ACT_CLEAR, 2'd0, 4'd6);
      push_word(ACT_CLEAR, 2'd3, 4'd0);    // core out of range
      push_word(ACT_CLEAR, 2'd1, 4'd15);   // class out of range
      push_word(ACT_CLEAR, 2'd2, 4'd10);   // first class past the table
      push_word(ACT_TICK,  2'd0, 4'd0);
      push_word(ACT_CLEAR, 2'd1, 4'd7);
      push_word(ACT_CLEAR, 2'd2, 4'd9);    // flag never set

      // every slot on, widest step and run length
      program_table(30'h3FFF_FFFF, 24'hFF_FFFF, 16'hFFFF);
      push_word(ACT_TICK,  2'd1, 4'd8);
      push_word(ACT_TICK,  2'd2, 4'd5);
      push_word(ACT_CLEAR, 2'd0, 4'd0);
      push_word(ACT_CLEAR, 2'd2, 4'd9);
      push_word(ACT_CLEAR, 2'd1, 4'd8);
      push_word(ACT_TICK,  2'd0, 4'd0);
      push_word(ACT_CLEAR, 2'd0, 4'd0);    // clear of a clear slot
      push_word(ACT_TICK,  2'd3, 4'd15);
      push_random(150, 80);

      // smallest step, random slots
      program_table(30'($urandom()), 24'd100000, 16'd1);
      push_random(140, 75);

      // nothing enabled: flags only drain
      program_table('0, 24'($urandom_range(100000, 16777215)),
                    16'($urandom_range(1, 65535)));
      push_random(60, 70);

      program_table(30'($urandom()), 24'hFF_FFFF, 16'($urandom_range(1, 65535)));
      push_random(120, 80);

      // last phase ends the run: lowered to one, lowered to the
      // current count, or reached 5 to 30 ticks later
      wait_drained();
      case ($urandom_range(0, 2))
         0: final_run_length = 24'd1;
         1: final_run_length = tick_count_sh;
         default: final_run_length = tick_count_sh + 24'($urandom_range(5, 30));
      endcase
      program_table(($urandom_range(0, 1) == 0) ? 30'h3FFF_FFFF : 30'($urandom()),
                    final_run_length, 16'($urandom_range(1, 65535)));
      push_random(90, 75);

      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && release_status_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
